// File: rtl/rftb_pkg.sv
`default_nettype none

package rftb_pkg;

    localparam int PEER_SLOTS_DEF = 16;
    localparam int ID_BITS_DEF    = 6;
    localparam int CNT_W          = 5;
    localparam logic [CNT_W-1:0] PEER_COUNT_RST = CNT_W'(10);

    typedef struct packed {
        logic valid;
        logic found;
        logic last;
    } tok_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/rftb_cell.sv
`default_nettype none

module rftb_cell #(
    parameter int ID_BITS  = rftb_pkg::ID_BITS_DEF,
    parameter int SLOT_W   = 4,
    parameter int FNUM_W   = 3,
    parameter int CELL_IDX = 0
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      wr_en,
    input  wire  [ID_BITS-1:0]       wr_id,
    input  wire                      active,
    input  wire rftb_pkg::tok_ctrl_t in_ctrl,
    input  wire  [FNUM_W-1:0]        in_fnum,
    input  wire  [ID_BITS-1:0]       in_key,
    input  wire  [ID_BITS-1:0]       in_best_id,
    input  wire  [SLOT_W-1:0]        in_best_slot,
    input  wire  [ID_BITS-1:0]       in_low_id,
    input  wire  [SLOT_W-1:0]        in_low_slot,
    output rftb_pkg::tok_ctrl_t      out_ctrl,
    output logic [FNUM_W-1:0]        out_fnum,
    output logic [ID_BITS-1:0]       out_key,
    output logic [ID_BITS-1:0]       out_best_id,
    output logic [SLOT_W-1:0]        out_best_slot,
    output logic [ID_BITS-1:0]       out_low_id,
    output logic [SLOT_W-1:0]        out_low_slot
);

    logic [ID_BITS-1:0] id_reg;

    rftb_pkg::tok_ctrl_t ctrl_reg, ctrl_next;
    logic [FNUM_W-1:0]  fnum_reg;
    logic [ID_BITS-1:0] key_reg;
    logic [ID_BITS-1:0] best_id_reg, best_id_next;
    logic [SLOT_W-1:0]  best_slot_reg, best_slot_next;
    logic [ID_BITS-1:0] low_id_reg, low_id_next;
    logic [SLOT_W-1:0]  low_slot_reg, low_slot_next;

    logic low_take;
    logic best_take;

    always_comb
    begin
        low_take  = active && (id_reg < in_low_id);
        best_take = active && (id_reg >= in_key) && (!in_ctrl.found || (id_reg < in_best_id));

        ctrl_next       = in_ctrl;
        ctrl_next.found = in_ctrl.found | best_take;
        best_id_next    = best_take ? id_reg : in_best_id;
        best_slot_next  = best_take ? SLOT_W'(CELL_IDX) : in_best_slot;
        low_id_next     = low_take ? id_reg : in_low_id;
        low_slot_next   = low_take ? SLOT_W'(CELL_IDX) : in_low_slot;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_reg <= wr_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fnum_reg      <= in_fnum;
        key_reg       <= in_key;
        best_id_reg   <= best_id_next;
        best_slot_reg <= best_slot_next;
        low_id_reg    <= low_id_next;
        low_slot_reg  <= low_slot_next;
    end

    assign out_ctrl      = ctrl_reg;
    assign out_fnum      = fnum_reg;
    assign out_key       = key_reg;
    assign out_best_id   = best_id_reg;
    assign out_best_slot = best_slot_reg;
    assign out_low_id    = low_id_reg;
    assign out_low_slot  = low_slot_reg;

endmodule

`default_nettype wire

// File: rtl/ring_finger_table_builder_core.sv
// Load word: accepted while not busy, no result; the next word can follow at once.
// Query word: fingers enter a chain of PEER_SLOTS cells one per cycle; results
// leave the chain end one per cycle, ID_BITS in all, the last one flagged.
// A query raises busy through the issue sequencer and holds it until its last
// result has left the chain end; the next word is taken once busy has fallen.
// Results cannot be stalled. Reset: control clear, peer_count 10, slot ids undefined.
`default_nettype none

module ring_finger_table_builder_core #(
    parameter  int PEER_SLOTS = rftb_pkg::PEER_SLOTS_DEF,
    parameter  int ID_BITS    = rftb_pkg::ID_BITS_DEF,
    localparam int SLOT_W     = $clog2(PEER_SLOTS),
    localparam int FNUM_W     = $clog2(ID_BITS)
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire                        cmd,
    input  wire  [SLOT_W-1:0]          slot_index,
    input  wire  [ID_BITS-1:0]         peer_id,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire  [rftb_pkg::CNT_W-1:0] cfg_data,
    output logic                       result_valid,
    output logic [FNUM_W-1:0]          finger_number,
    output logic [ID_BITS-1:0]         finger_key,
    output logic [SLOT_W-1:0]          owner_slot,
    output logic [ID_BITS-1:0]         owner_id,
    output logic                       last_finger
);

    localparam int CNT_W = rftb_pkg::CNT_W;

    logic [CNT_W-1:0]   peer_count_reg;
    logic               issuing_reg, issuing_next;
    logic [FNUM_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic [ID_BITS-1:0] node_reg, node_next;

    logic accept;
    logic issue_last;
    logic in_flight;

    rftb_pkg::tok_ctrl_t ctrl_s      [0:PEER_SLOTS];
    logic [FNUM_W-1:0]   fnum_s      [0:PEER_SLOTS];
    logic [ID_BITS-1:0]  key_s       [0:PEER_SLOTS];
    logic [ID_BITS-1:0]  best_id_s   [0:PEER_SLOTS];
    logic [SLOT_W-1:0]   best_slot_s [0:PEER_SLOTS];
    logic [ID_BITS-1:0]  low_id_s    [0:PEER_SLOTS];
    logic [SLOT_W-1:0]   low_slot_s  [0:PEER_SLOTS];

    logic [PEER_SLOTS-1:0] wr_en;
    logic [PEER_SLOTS-1:0] active;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_count_reg <= rftb_pkg::PEER_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            peer_count_reg <= cfg_data;
        end
    end

    // finger issue sequencer
    assign issue_last = (issue_cnt_reg == FNUM_W'(ID_BITS - 1));

    always_comb
    begin
        issuing_next   = issuing_reg;
        issue_cnt_next = issue_cnt_reg;
        node_next      = node_reg;
        if (accept && cmd)
        begin
            issuing_next   = 1'b1;
            issue_cnt_next = '0;
            node_next      = peer_id;
        end
        else if (issuing_reg)
        begin
            issue_cnt_next = issue_cnt_reg + 1'b1;
            if (issue_last)
            begin
                issuing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg   <= 1'b0;
            issue_cnt_reg <= '0;
        end
        else
        begin
            issuing_reg   <= issuing_next;
            issue_cnt_reg <= issue_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
    end

    // chain head: fresh search token
    always_comb
    begin
        ctrl_s[0].valid = issuing_reg;
        ctrl_s[0].found = 1'b0;
        ctrl_s[0].last  = issue_last;
        fnum_s[0]       = issue_cnt_reg;
        key_s[0]        = node_reg + (ID_BITS'(1) << issue_cnt_reg);
        best_id_s[0]    = '0;
        best_slot_s[0]  = '0;
        low_id_s[0]     = '1;
        low_slot_s[0]   = '0;
    end

    for (genvar i = 0; i < PEER_SLOTS; i++)
    begin : g_cell
        assign wr_en[i]  = accept && !cmd && (slot_index == SLOT_W'(i));
        assign active[i] = (i == 0) || (32'(i) < 32'(peer_count_reg));

        rftb_cell #(
            .ID_BITS  (ID_BITS),
            .SLOT_W   (SLOT_W),
            .FNUM_W   (FNUM_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .wr_en         (wr_en[i]),
            .wr_id         (peer_id),
            .active        (active[i]),
            .in_ctrl       (ctrl_s[i]),
            .in_fnum       (fnum_s[i]),
            .in_key        (key_s[i]),
            .in_best_id    (best_id_s[i]),
            .in_best_slot  (best_slot_s[i]),
            .in_low_id     (low_id_s[i]),
            .in_low_slot   (low_slot_s[i]),
            .out_ctrl      (ctrl_s[i+1]),
            .out_fnum      (fnum_s[i+1]),
            .out_key       (key_s[i+1]),
            .out_best_id   (best_id_s[i+1]),
            .out_best_slot (best_slot_s[i+1]),
            .out_low_id    (low_id_s[i+1]),
            .out_low_slot  (low_slot_s[i+1])
        );
    end

    always_comb
    begin
        in_flight = 1'b0;
        for (int k = 1; k <= PEER_SLOTS; k++)
        begin
            in_flight = in_flight | ctrl_s[k].valid;
        end
    end

    assign busy = issuing_reg || in_flight;

    // no id at or above key: wrap to smallest id
    assign result_valid  = ctrl_s[PEER_SLOTS].valid;
    assign last_finger   = ctrl_s[PEER_SLOTS].last;
    assign finger_number = fnum_s[PEER_SLOTS];
    assign finger_key    = key_s[PEER_SLOTS];
    assign owner_slot    = ctrl_s[PEER_SLOTS].found ? best_slot_s[PEER_SLOTS]
                                                    : low_slot_s[PEER_SLOTS];
    assign owner_id      = ctrl_s[PEER_SLOTS].found ? best_id_s[PEER_SLOTS]
                                                    : low_id_s[PEER_SLOTS];

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd) |=> busy)
        else $error("query accepted without raising busy");

    a_owner_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((owner_slot == '0) || (32'(owner_slot) < 32'(peer_count_reg))))
        else $error("owner slot outside slots in use");

    a_finger_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_finger) |=>
            (result_valid && (finger_number == FNUM_W'($past(finger_number) + 1'b1))))
        else $error("finger results not consecutive");

    a_last_number: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_finger) |-> (finger_number == FNUM_W'(ID_BITS - 1)))
        else $error("last finger flag on wrong finger");

endmodule

`default_nettype wire

// File: sim/ring_finger_table_builder_core_tb.sv
`timescale 1ns / 1ps

module ring_finger_table_builder_core_tb;

    localparam int PEER_SLOTS     = 16;
    localparam int ID_BITS        = 6;
    localparam int SETTLE_CYCLES  = PEER_SLOTS + ID_BITS + 8;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int CNT_W          = rftb_pkg::CNT_W;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct {
        logic [2:0] number;
        logic [5:0] key;
        logic [3:0] slot;
        logic [5:0] owner;
        logic       last;
    } finger_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             cmd;
    logic [3:0]       slot_index;
    logic [5:0]       peer_id;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;
    logic             result_valid;
    logic [2:0]       finger_number;
    logic [5:0]       finger_key;
    logic [3:0]       owner_slot;
    logic [5:0]       owner_id;
    logic             last_finger;

    logic [5:0]       ring_model [PEER_SLOTS];
    logic [CNT_W-1:0] peer_count_model;
    finger_t          pending_fingers [$];
    bit               sender_idles;
    int               error_count;
    int               cycle_count;
    int               load_count;
    int               query_count;
    int               finger_count;
    int               setting_count;

    ring_finger_table_builder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .slot_index    (slot_index),
        .peer_id       (peer_id),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .finger_number (finger_number),
        .finger_key    (finger_key),
        .owner_slot    (owner_slot),
        .owner_id      (owner_id),
        .last_finger   (last_finger)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("tb: timeout with %0d fingers outstanding", pending_fingers.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch on %s at cycle %0d: got %0d, want %0d",
                 what, cycle_count, got, want);
        error_count++;
    endtask

    // Successor search over the slots in use, lowest slot wins on ties.
    function automatic void queue_fingers(input logic [5:0] node);
        int      in_use;
        int      best;
        int      lowest;
        bit      found;
        finger_t f;
        in_use = int'(peer_count_model);
        if (in_use < 1)
            in_use = 1;
        if (in_use > PEER_SLOTS)
            in_use = PEER_SLOTS;
        for (int j = 0; j < ID_BITS; j++)
        begin
            f.number = 3'(j);
            f.key    = node + (6'd1 << j);
            found    = 1'b0;
            best     = 0;
            lowest   = 0;
            for (int i = 0; i < in_use; i++)
            begin
                if (ring_model[i] < ring_model[lowest])
                    lowest = i;
                if (ring_model[i] >= f.key && (!found || ring_model[i] < ring_model[best]))
                begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (!found)
                best = lowest;
            f.slot  = 4'(best);
            f.owner = ring_model[best];
            f.last  = (j == ID_BITS - 1);
            pending_fingers.push_back(f);
        end
    endfunction

    always @(posedge clk)
    begin
        finger_t want;
        if (rst_n && result_valid)
        begin
            if (pending_fingers.size() == 0)
            begin
                $display("tb: unexpected result word at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                want = pending_fingers.pop_front();
                finger_count++;
                if (finger_number !== want.number)
                    report_mismatch("finger_number", int'(finger_number), int'(want.number));
                if (finger_key !== want.key)
                    report_mismatch("finger_key", int'(finger_key), int'(want.key));
                if (owner_slot !== want.slot)
                    report_mismatch("owner_slot", int'(owner_slot), int'(want.slot));
                if (owner_id !== want.owner)
                    report_mismatch("owner_id", int'(owner_id), int'(want.owner));
                if (last_finger !== want.last)
                    report_mismatch("last_finger", int'(last_finger), int'(want.last));
            end
        end
    end

    task automatic send_word(input logic op, input logic [3:0] slot, input logic [5:0] id);
        int gap;
        gap = sender_idles ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= op;
        slot_index <= slot;
        peer_id    <= id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == OP_QUERY)
        begin
            queue_fingers(id);
            query_count++;
        end
        else
        begin
            ring_model[slot] = id;
            load_count++;
        end
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_fingers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_peer_count(input logic [CNT_W-1:0] value);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        peer_count_model = value;
        setting_count++;
    endtask

    // every slot gets written before any query, with 0, 63 and duplicates
    task automatic test_fill_ring();
        logic [5:0] ids [PEER_SLOTS] = '{40, 63, 0, 17, 40, 5, 52, 17,
                                         30, 8, 63, 1, 0, 45, 22, 60};
        for (int s = 0; s < PEER_SLOTS; s++)
            send_word(OP_LOAD, 4'(s), ids[s]);
    endtask

    // reset peer_count: node 0, node 63 (key wraps), exact hit, tie on 17
    task automatic test_reset_count_queries();
        send_word(OP_QUERY, 4'd9, 6'd0);
        send_word(OP_QUERY, 4'd0, 6'd63);
        send_word(OP_QUERY, 4'd15, 6'd39);
        send_word(OP_QUERY, 4'd6, 6'd16);
    endtask

    // zero clamps to one slot, above sixteen saturates
    task automatic test_count_extremes();
        logic [CNT_W-1:0] counts [5] = '{0, 1, 16, 17, 31};
        foreach (counts[k])
        begin
            write_peer_count(counts[k]);
            send_word(OP_QUERY, 4'($urandom), 6'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        logic       op;
        logic [5:0] id;
        for (int phase = 0; phase < 8; phase++)
        begin
            write_peer_count(CNT_W'($urandom_range(0, 31)));
            sender_idles = (phase % 3 != 1) && $urandom_range(0, 3) != 0;
            for (int n = 0; n < 30; n++)
            begin
                op = ($urandom_range(0, 99) < 40) ? OP_QUERY : OP_LOAD;
                if ($urandom_range(0, 3) == 0)
                    id = 6'($urandom_range(0, 7) * 9);
                else
                    id = 6'($urandom);
                send_word(op, 4'($urandom), id);
            end
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        start            <= 1'b0;
        cmd              <= OP_LOAD;
        slot_index       <= '0;
        peer_id          <= '0;
        cfg_valid        <= 1'b0;
        cfg_data         <= '0;
        peer_count_model  = rftb_pkg::PEER_COUNT_RST;
        sender_idles      = 1'b1;
        error_count       = 0;
        cycle_count       = 0;
        load_count        = 0;
        query_count       = 0;
        finger_count      = 0;
        setting_count     = 0;
        foreach (ring_model[s])
            ring_model[s] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_ring();
        test_reset_count_queries();
        test_count_extremes();
        test_random_traffic();

        wait_quiet();
        $display("tb: %0d loads and %0d queries sent, %0d finger words checked",
                 load_count, query_count, finger_count);
        $display("tb: %0d peer_count settings incl. 0, 1, 16, 17 and 31", setting_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
rtl/rftb_pkg.sv
rtl/rftb_cell.sv
rtl/ring_finger_table_builder_core.sv
sim/ring_finger_table_builder_core_tb.sv
